[hdl/mna_pkg.sv]
`default_nettype none

package mna_pkg;

    // Fixed field widths of the item and result formats.
    localparam int NODE_W    = 6;
    localparam int VALUE_W   = 32;
    localparam int DATA_W    = 48;
    localparam int RHS_W     = 32;
    localparam int NCOUNT_W  = 6;

    // Reciprocal divider: 2^40 divided by a positive Q24.8 resistance.
    localparam int DIVISOR_W = 31;
    localparam int QUO_W     = 41;
    localparam int REM_W     = 32;
    localparam int DIV_STEPS = QUO_W;

    localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = 6'd32;

    // Q16.32 constants for the coupling entries and for saturation.
    localparam logic signed [DATA_W-1:0] ONE_Q32     = 48'sh0001_0000_0000;
    localparam logic signed [DATA_W-1:0] NEG_ONE_Q32 = -48'sh0001_0000_0000;
    localparam logic signed [DATA_W-1:0] SAT_MAX     = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN     = 48'sh8000_0000_0000;

    typedef enum logic [1:0] {
        OP_RES    = 2'd0,
        OP_SRC    = 2'd1,
        OP_RD_MAT = 2'd2,
        OP_RD_RHS = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_RES  = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_SRC_FULL = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_RMW,
        ST_FINISH,
        ST_FETCH,
        ST_LOAD,
        ST_RESP
    } state_t;

    typedef struct packed {
        op_t                        op;
        logic [NODE_W-1:0]          node_a;
        logic [NODE_W-1:0]          node_b;
        logic signed [VALUE_W-1:0]  value;
        logic [NODE_W-1:0]          row;
        logic [NODE_W-1:0]          col;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   read_data;
        status_t                    status;
    } out_t;

    // Write strobes from the sequencer to the storage.
    typedef struct packed {
        logic mat_we;
        logic rhs_we;
    } store_cmd_t;

    // Adds a signed delta to a matrix entry and clamps to the 48-bit range.
    function automatic logic signed [DATA_W-1:0] sat_add48(
        input logic signed [DATA_W-1:0] acc,
        input logic signed [DATA_W:0]   delta
    );
        logic signed [DATA_W:0] sum;
        sum = {acc[DATA_W-1], acc} + delta;
        if (sum[DATA_W] != sum[DATA_W-1]) begin
            return sum[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        return sum[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/mna_matrix_stamper.sv]
// Modified nodal analysis stamper.
// Items arrive on the s_ channel (valid/ready) as one in_t each and every item
// produces exactly one out_t on the m_ channel (valid/ready). The block works
// on one item at a time: s_ready is high only while it is idle.
// cfg_wr_en/cfg_wr_data write node_count at once; write it only while idle.
// Paths from the input transfer to m_valid: a rejected item (range,
// resistance or source count) goes straight to the result; a matrix or rhs
// read passes the fetch and load states; a voltage source and a resistor
// pass the four stamp steps and a finish state, a resistor after the
// reciprocal division.
// A resistor is dominated by the bit-serial reciprocal divider (41 steps),
// followed by up to four read-modify-write passes on the
// single-port matrix memory. Sources take up to four plain matrix writes.
// The next item is taken the cycle after the result transfer.
// Reset (aresetn, synchronous, active low) starts a clearing pass over the
// whole matrix, during which s_ready stays low; configuration writes are
// taken meanwhile.
// A stalled receiver simply holds the result in the output register.
`default_nettype none

module mna_matrix_stamper
    import mna_pkg::*;
#(
    parameter int MAX_NODES   = 32,
    parameter int MAX_SOURCES = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_t                  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_t                      m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [NCOUNT_W-1:0]  cfg_wr_data
);

    localparam int DIM = MAX_NODES + MAX_SOURCES;
    localparam int RW  = $clog2(DIM);
    localparam int MA  = $clog2(DIM * DIM);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int SCW = $clog2(MAX_SOURCES + 1);

    state_t               state_reg, state_next;
    in_t                  item_reg, item_next;
    out_t                 out_reg, out_next;
    logic [1:0]           step_reg, step_next;
    logic [QUO_W-1:0]     g_reg, g_next;
    logic [SCW-1:0]       sc_reg, sc_next;
    logic [NCOUNT_W-1:0]  node_count_reg;

    logic [NCW-1:0]       nc;
    logic                 a_nz, b_nz, is_src, step_en;
    logic [RW-1:0]        a_idx, b_idx, s_idx, row_sel, col_sel;
    logic [MA-1:0]        mat_addr;
    logic [RW-1:0]        rhs_addr;
    logic signed [DATA_W-1:0] mat_wdata, mat_rdata;
    logic signed [RHS_W-1:0]  rhs_rdata;
    logic signed [DATA_W:0]   g_ext, delta;
    logic                 init_done;
    logic                 div_start, div_done;
    logic [QUO_W-1:0]     quotient;
    store_cmd_t           store_cmd;

    // Node count as seen by the stamps, clamped to MAX_NODES.
    always_comb begin
        nc = (int'(node_count_reg) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count_reg);
    end

    // Entry selection for the four stamp steps of the current item.
    always_comb begin
        a_nz   = item_reg.node_a != '0;
        b_nz   = item_reg.node_b != '0;
        is_src = item_reg.op == OP_SRC;
        a_idx  = RW'(item_reg.node_a - 1'b1);
        b_idx  = RW'(item_reg.node_b - 1'b1);
        s_idx  = RW'(nc) + RW'(sc_reg);
        row_sel = a_idx;
        col_sel = a_idx;
        step_en = 1'b0;
        case (step_reg)
            2'd0: begin
                row_sel = a_idx;
                col_sel = is_src ? s_idx : a_idx;
                step_en = a_nz;
            end
            2'd1: begin
                row_sel = is_src ? s_idx : b_idx;
                col_sel = is_src ? a_idx : b_idx;
                step_en = is_src ? a_nz : b_nz;
            end
            2'd2: begin
                row_sel = b_idx;
                col_sel = is_src ? s_idx : a_idx;
                row_sel = is_src ? b_idx : a_idx;
                col_sel = is_src ? s_idx : b_idx;
                step_en = is_src ? b_nz : (a_nz && b_nz);
            end
            default: begin
                row_sel = is_src ? s_idx : b_idx;
                col_sel = is_src ? b_idx : a_idx;
                step_en = is_src ? b_nz : (a_nz && b_nz);
            end
        endcase
        if (state_reg == ST_FETCH) begin
            row_sel = RW'(item_reg.row);
            col_sel = RW'(item_reg.col);
        end
        mat_addr = MA'(row_sel) * MA'(DIM) + MA'(col_sel);
        rhs_addr = (state_reg == ST_FETCH) ? RW'(item_reg.row) : s_idx;
    end

    // Conductance delta: added on the diagonal steps, subtracted on the cross steps.
    always_comb begin
        g_ext = $signed({{(DATA_W + 1 - QUO_W){1'b0}}, g_reg});
        delta = step_reg[1] ? -g_ext : g_ext;
    end

    // Sequencer: next state, datapath control and result register contents.
    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        out_next   = out_reg;
        step_next  = step_reg;
        g_next     = g_reg;
        sc_next    = sc_reg;
        store_cmd  = '0;
        div_start  = 1'b0;
        mat_wdata  = step_reg[1] ? NEG_ONE_Q32 : ONE_Q32;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next          = s_data;
                    step_next          = 2'd0;
                    out_next.read_data = '0;
                    out_next.status    = STAT_OK;
                    if (s_data.op == OP_RES || s_data.op == OP_SRC) begin
                        if (int'(s_data.node_a) > int'(nc)
                                || int'(s_data.node_b) > int'(nc)) begin
                            out_next.status = STAT_RANGE;
                            state_next      = ST_RESP;
                        end else if (s_data.op == OP_RES) begin
                            if (s_data.value <= 0) begin
                                out_next.status = STAT_BAD_RES;
                                state_next      = ST_RESP;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end else if (int'(sc_reg) >= MAX_SOURCES) begin
                            out_next.status = STAT_SRC_FULL;
                            state_next      = ST_RESP;
                        end else begin
                            state_next = ST_STEP;
                        end
                    end else if (s_data.op == OP_RD_MAT) begin
                        if (int'(s_data.row) < DIM && int'(s_data.col) < DIM) begin
                            state_next = ST_FETCH;
                        end else begin
                            out_next.status = STAT_RANGE;
                            state_next      = ST_RESP;
                        end
                    end else begin
                        if (int'(s_data.row) < DIM) begin
                            state_next = ST_FETCH;
                        end else begin
                            out_next.status = STAT_RANGE;
                            state_next      = ST_RESP;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    g_next     = quotient;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (step_en && !is_src) begin
                    // Resistor entry: the read is under way, update it next cycle.
                    state_next = ST_RMW;
                end else begin
                    store_cmd.mat_we = step_en;
                    if (step_reg == 2'd3) begin
                        state_next = ST_FINISH;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_RMW: begin
                store_cmd.mat_we = 1'b1;
                mat_wdata        = sat_add48(mat_rdata, delta);
                if (step_reg == 2'd3) begin
                    state_next = ST_FINISH;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_FINISH: begin
                if (is_src) begin
                    store_cmd.rhs_we = 1'b1;
                    sc_next          = sc_reg + 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_FETCH: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (item_reg.op == OP_RD_MAT) begin
                    out_next.read_data = mat_rdata;
                end else begin
                    out_next.read_data = DATA_W'(rhs_rdata);
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sc_reg         <= '0;
            node_count_reg <= NODE_COUNT_RESET;
        end else begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
        end
    end

    // Item, conductance, step index and result payload.
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        out_reg  <= out_next;
        step_reg <= step_next;
        g_reg    <= g_next;
    end

    mna_recip_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (s_data.value[DIVISOR_W-1:0]),
        .done     (div_done),
        .quotient (quotient)
    );

    mna_store #(
        .DIM (DIM)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (store_cmd),
        .mat_addr  (mat_addr),
        .mat_wdata (mat_wdata),
        .rhs_addr  (rhs_addr),
        .rhs_wdata (item_reg.value),
        .mat_rdata (mat_rdata),
        .rhs_rdata (rhs_rdata),
        .init_done (init_done)
    );

    assign s_ready = (state_reg == ST_IDLE) && init_done;
    assign m_valid = state_reg == ST_RESP;
    assign m_data  = out_reg;

    // A new item is never taken while a result is still pending.
    a_ready_excl_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while a result is pending");

    // The source counter never passes the number of source rows.
    a_src_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(sc_reg) <= MAX_SOURCES)
        else $error("source count overflow");

    // Only a voltage source writes the right-hand side.
    a_rhs_by_src: assert property (@(posedge aclk) disable iff (!aresetn)
        store_cmd.rhs_we |-> item_reg.op == OP_SRC && state_reg == ST_FINISH)
        else $error("unexpected right-hand-side write");

    // A finished division moves the sequencer on to the stamp steps.
    a_div_to_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_done) |=> state_reg == ST_STEP)
        else $error("conductance not taken after division");

endmodule

`default_nettype wire

[hdl/mna_recip_div.sv]
`default_nettype none

module mna_recip_div
    import mna_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [QUO_W-1:0]           quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    logic                 run_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] div_reg;

    logic [REM_W-1:0]     rem_shift;
    logic [REM_W:0]       diff;
    logic                 qbit;
    logic [REM_W-1:0]     rem_next;

    // One restoring step per cycle. The dividend is 2^40, so its only set bit
    // enters on the first step.
    always_comb begin
        rem_shift = {rem_reg[REM_W-2:0], cnt_reg == '0};
        diff      = {1'b0, rem_shift} - {{(REM_W + 1 - DIVISOR_W){1'b0}}, div_reg};
        qbit      = ~diff[REM_W];
        rem_next  = qbit ? diff[REM_W-1:0] : rem_shift;
    end

    // Step counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= '0;
            div_reg <= divisor;
        end else if (run_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // The sequencer only ever divides by a positive resistance.
    a_nonzero_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> divisor != '0)
        else $error("divider started with a zero divisor");

    // A finished division leaves a remainder below the divisor.
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> rem_reg < {1'b0, div_reg})
        else $error("divider remainder not reduced");

    // Completion follows a running division.
    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(run_reg) && !run_reg)
        else $error("divider done without a running division");

endmodule

`default_nettype wire

[hdl/mna_store.sv]
`default_nettype none

module mna_store
    import mna_pkg::*;
#(
    parameter  int DIM = 40,
    localparam int RW  = $clog2(DIM),
    localparam int MA  = $clog2(DIM * DIM)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire store_cmd_t                 cmd,
    input  wire logic [MA-1:0]              mat_addr,
    input  wire logic signed [DATA_W-1:0]   mat_wdata,
    input  wire logic [RW-1:0]              rhs_addr,
    input  wire logic signed [RHS_W-1:0]    rhs_wdata,
    output logic signed [DATA_W-1:0]        mat_rdata,
    output logic signed [RHS_W-1:0]         rhs_rdata,
    output logic                            init_done
);

    localparam logic [MA-1:0] CLR_LAST = MA'(DIM * DIM - 1);
    localparam logic [MA-1:0] RHS_LIMIT = MA'(DIM);

    logic signed [DATA_W-1:0] mat_mem [DIM * DIM];
    logic signed [RHS_W-1:0]  rhs_mem [DIM];

    logic [MA-1:0]            clr_reg;
    logic                     init_done_reg;
    logic signed [DATA_W-1:0] mat_rdata_reg;
    logic signed [RHS_W-1:0]  rhs_rdata_reg;

    // Clearing pass after reset: one matrix entry per cycle, and the
    // right-hand side alongside while the index is below its depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            init_done_reg <= 1'b0;
        end else if (!init_done_reg) begin
            if (clr_reg == CLR_LAST) begin
                init_done_reg <= 1'b1;
            end else begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // Matrix memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (!init_done_reg) begin
            mat_mem[clr_reg] <= '0;
        end else if (cmd.mat_we) begin
            mat_mem[mat_addr] <= mat_wdata;
        end
        mat_rdata_reg <= mat_mem[mat_addr];
    end

    // Right-hand-side memory.
    always_ff @(posedge aclk) begin
        if (!init_done_reg) begin
            if (clr_reg < RHS_LIMIT) begin
                rhs_mem[RW'(clr_reg)] <= '0;
            end
        end else if (cmd.rhs_we) begin
            rhs_mem[rhs_addr] <= rhs_wdata;
        end
        rhs_rdata_reg <= rhs_mem[rhs_addr];
    end

    assign mat_rdata = mat_rdata_reg;
    assign rhs_rdata = rhs_rdata_reg;
    assign init_done = init_done_reg;

    // Once the clearing pass ends it never restarts without reset.
    a_init_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        init_done_reg |=> init_done_reg)
        else $error("clearing pass restarted");

    // The pass ends only after the last entry was cleared.
    a_init_full_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(init_done_reg) |-> $past(clr_reg) == CLR_LAST)
        else $error("clearing pass ended early");

    // No functional write may arrive while the memories are being cleared.
    a_no_write_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mat_we || cmd.rhs_we) |-> init_done_reg)
        else $error("write during clearing pass");

endmodule

`default_nettype wire
